[rtl/core/differential_drive_odometry_top_macros.svh]
// ----------------------------------------------------------------------------
// differential drive odometry assertion macros
// concurrent assertion helpers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_TOP_MACROS_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// antecedent must be followed in the same cycle by the consequent
`define DDO_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent must be followed in the next cycle by the consequent
`define DDO_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define DDO_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define DDO_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

[rtl/core/ddo_pkg.sv]
// ----------------------------------------------------------------------------
// ddo_pkg
// shared widths, register indexes, reset values and controller/datapath types
// ----------------------------------------------------------------------------
package ddo_pkg;

  localparam int TIME_W    = 32;
  localparam int COUNT_W   = 32;
  localparam int POS_W     = 48;
  localparam int HEADOUT_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;
  localparam int DPC_W     = 32;
  localparam int IWB_W     = 24;
  localparam int MINT_W    = 20;
  localparam int TRIG_W    = 17;

  localparam logic [CFG_IDX_W-1:0] REG_DIST_PER_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_WHEEL_BASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL   = 2'd2;

  localparam logic [DPC_W-1:0]  DPC_RESET  = 32'd589242;
  localparam logic [IWB_W-1:0]  IWB_RESET  = 24'd30678;
  localparam logic [MINT_W-1:0] MINT_RESET = 20'd10000;

  // quarter turn in radians, Q2.30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam logic signed [POS_W-1:0] POS_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [POS_W-1:0] POS_MIN = 48'sh8000_0000_0000;

  typedef enum logic [1:0] {
    MUL_TRAVEL  = 2'd0,
    MUL_MOVE_LO = 2'd1,
    MUL_MOVE_HI = 2'd2,
    MUL_TURN    = 2'd3
  } mul_sel_t;

  typedef struct packed {
    logic     capture;
    logic     check;
    logic     set_first;
    logic     commit;
    logic     load_dl;
    logic     load_dr;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     load_tl;
    logic     load_tr;
    logic     load_sum;
    logic     load_mean;
    logic     rom_rd;
    logic     rom_cos;
    logic     save_lo;
    logic     load_move;
    logic     upd_x;
    logic     upd_y;
    logic     upd_head;
    logic     load_out;
  } ddo_cmd_t;

  typedef struct packed {
    logic acc;
    logic first_seen;
  } ddo_status_t;

endpackage

[rtl/core/ddo_sample_if.sv]
// ----------------------------------------------------------------------------
// ddo_sample_if
// encoder sample channel: time stamp and cumulative wheel counts
// ----------------------------------------------------------------------------
interface ddo_sample_if;
  logic                                valid;
  logic                                ready;
  logic        [ddo_pkg::TIME_W-1:0]  time_stamp;
  logic signed [ddo_pkg::COUNT_W-1:0] left_count;
  logic signed [ddo_pkg::COUNT_W-1:0] right_count;

  modport source (output valid, time_stamp, left_count, right_count, input ready);
  modport sink   (input valid, time_stamp, left_count, right_count, output ready);
endinterface

[rtl/core/ddo_pose_if.sv]
// ----------------------------------------------------------------------------
// ddo_pose_if
// pose result channel: accept flag, position and heading
// ----------------------------------------------------------------------------
interface ddo_pose_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  accepted;
  logic signed [ddo_pkg::POS_W-1:0]     x_pos;
  logic signed [ddo_pkg::POS_W-1:0]     y_pos;
  logic        [ddo_pkg::HEADOUT_W-1:0] heading;

  modport source (output valid, accepted, x_pos, y_pos, heading, input ready);
  modport sink   (input valid, accepted, x_pos, y_pos, heading, output ready);
endinterface

[rtl/core/ddo_cfg_if.sv]
// ----------------------------------------------------------------------------
// ddo_cfg_if
// configuration write channel: register index and write data
// ----------------------------------------------------------------------------
interface ddo_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [ddo_pkg::CFG_IDX_W-1:0]    index;
  logic [ddo_pkg::CFG_DAT_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/ddo_sine_rom.sv]
// ----------------------------------------------------------------------------
// ddo_sine_rom
// quarter-wave sine table, Q1.16, built at elaboration, registered read
// ----------------------------------------------------------------------------
module ddo_sine_rom #(
  parameter int DEPTH = 256,
  localparam int IDX_W = $clog2(DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rd,
  input  logic [IDX_W-1:0]            addr,
  output logic [ddo_pkg::TRIG_W-1:0]  data
);

  logic [ddo_pkg::TRIG_W-1:0] sine_rom [DEPTH+1];

  // integer taylor series, six terms past x
  for (genvar k = 0; k <= DEPTH; k++) begin : g_entry
    localparam logic [63:0] X  = (64'(k) * ddo_pkg::HALF_PI_Q30) / 64'(DEPTH);
    localparam logic [63:0] X2 = (X * X) >> 30;
    localparam logic [63:0] T1 = ((X  * X2) >> 30) / 64'd6;
    localparam logic [63:0] T2 = ((T1 * X2) >> 30) / 64'd20;
    localparam logic [63:0] T3 = ((T2 * X2) >> 30) / 64'd42;
    localparam logic [63:0] T4 = ((T3 * X2) >> 30) / 64'd72;
    localparam logic [63:0] T5 = ((T4 * X2) >> 30) / 64'd110;
    localparam logic [63:0] T6 = ((T5 * X2) >> 30) / 64'd156;
    localparam logic signed [63:0] SUM = $signed(X) - $signed(T1) + $signed(T2)
                                       - $signed(T3) + $signed(T4) - $signed(T5)
                                       + $signed(T6);
    localparam logic [63:0] POSV  = (SUM < 0) ? 64'd0 : 64'(SUM);
    localparam logic [63:0] Q     = (POSV + 64'd8192) / 64'd16384;
    localparam logic [ddo_pkg::TRIG_W-1:0] ENTRY =
      (Q > 64'd65536) ? 17'd65536 : Q[ddo_pkg::TRIG_W-1:0];
    assign sine_rom[k] = ENTRY;
  end

  always_ff @(posedge clk) begin
    if (rd) begin
      data <= sine_rom[addr];
    end
  end

endmodule

[rtl/core/ddo_datapath.sv]
// ----------------------------------------------------------------------------
// ddo_datapath
// odometry state, config registers, shared 32x32 multiplier and sine lookup
// ----------------------------------------------------------------------------
module ddo_datapath #(
  parameter int HEADING_BITS     = 16,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic        [ddo_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [ddo_pkg::CFG_DAT_W-1:0]  cfg_data,
  input  logic        [ddo_pkg::TIME_W-1:0]     time_stamp,
  input  logic signed [ddo_pkg::COUNT_W-1:0]    left_count,
  input  logic signed [ddo_pkg::COUNT_W-1:0]    right_count,
  input  ddo_pkg::ddo_cmd_t                     cmd,
  output ddo_pkg::ddo_status_t                  status,
  output logic                                  accepted,
  output logic signed [ddo_pkg::POS_W-1:0]      x_pos,
  output logic signed [ddo_pkg::POS_W-1:0]      y_pos,
  output logic        [ddo_pkg::HEADOUT_W-1:0]  heading
);

  localparam int HB     = HEADING_BITS;
  localparam int RW     = HB - 2;
  localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int AMUL_W = RW + IDX_W + 1;

  localparam logic [HB-1:0]     QUARTER    = {2'b01, {RW{1'b0}}};
  localparam logic [AMUL_W-1:0] ROUND_IDX  = AMUL_W'(1) << (RW - 1);
  localparam logic [AMUL_W-1:0] DEPTH_W    = AMUL_W'(SINE_TABLE_DEPTH);
  localparam logic [IDX_W-1:0]  DEPTH_IDX  = IDX_W'(SINE_TABLE_DEPTH);
  localparam logic [32:0]       HEAD_ROUND = 33'(1) << (31 - HB);

  // config
  logic [ddo_pkg::DPC_W-1:0]  dist_per_count;
  logic [ddo_pkg::IWB_W-1:0]  inv_wheel_base;
  logic [ddo_pkg::MINT_W-1:0] min_interval;

  // captured sample
  logic [31:0] in_t;
  logic [31:0] in_l;
  logic [31:0] in_r;

  // odometry state
  logic [31:0]                     prev_left;
  logic [31:0]                     prev_right;
  logic [31:0]                     last_time;
  logic                            first_seen;
  logic signed [ddo_pkg::POS_W-1:0] pos_x;
  logic signed [ddo_pkg::POS_W-1:0] pos_y;
  logic [HB-1:0]                   head;

  // working registers
  logic                       acc_q;
  logic [31:0]                dmag;
  logic                       dneg;
  logic [63:0]                prod;
  logic signed [48:0]         tl;
  logic signed [48:0]         tr;
  logic signed [49:0]         wsum;
  logic [31:0]                diff32;
  logic [47:0]                mean_mag;
  logic                       mean_neg;
  logic                       trig_neg;
  logic [48:0]                plo;
  logic signed [48:0]         move;
  logic [ddo_pkg::TRIG_W-1:0] rom_q;

  // output register
  logic                            out_acc;
  logic signed [ddo_pkg::POS_W-1:0] out_x;
  logic signed [ddo_pkg::POS_W-1:0] out_y;
  logic [ddo_pkg::HEADOUT_W-1:0]   out_head;
  logic [ddo_pkg::HEADOUT_W-1:0]   head16;

  // combinational
  logic [31:0]       gap;
  logic [32:0]       dsel;
  logic [32:0]       dabs;
  logic [63:0]       trav_sum;
  logic [47:0]       trav_mag;
  logic signed [48:0] trav_val;
  logic [49:0]       mabs;
  logic [65:0]       mv_sum;
  logic [47:0]       mv_mag;
  logic [32:0]       turn_sum;
  logic [HB-1:0]     step;
  logic [31:0]       mul_a;
  logic [31:0]       mul_b;
  logic [HB-1:0]     ang;
  logic [1:0]        quad;
  logic [RW-1:0]     frac;
  logic [AMUL_W-1:0] idx_wide;
  logic [IDX_W-1:0]  idx_c;
  logic [IDX_W-1:0]  rom_addr;

  function automatic logic signed [ddo_pkg::POS_W-1:0] sat_add(
    input logic signed [ddo_pkg::POS_W-1:0] p,
    input logic signed [48:0]               m
  );
    logic signed [49:0] s;
    s = {{2{p[47]}}, p} + {m[48], m};
    if (s[49:47] == 3'b000 || s[49:47] == 3'b111) begin
      return s[47:0];
    end else if (s[49]) begin
      return ddo_pkg::POS_MIN;
    end else begin
      return ddo_pkg::POS_MAX;
    end
  endfunction

  assign gap = in_t - last_time;
  assign status.acc        = gap > {12'd0, min_interval};
  assign status.first_seen = first_seen;

  // wheel count delta, magnitude always fits 32 bits
  assign dsel = cmd.load_dr ? ({in_r[31], in_r} - {prev_right[31], prev_right})
                            : ({in_l[31], in_l} - {prev_left[31], prev_left});
  assign dabs = dsel[32] ? (33'd0 - dsel) : dsel;

  assign trav_sum = prod + 64'd32768;
  assign trav_mag = trav_sum[63:16];
  assign trav_val = dneg ? (49'sd0 - $signed({1'b0, trav_mag})) : $signed({1'b0, trav_mag});

  assign mabs = wsum[49] ? (50'd0 - wsum) : wsum;

  assign mv_sum = 66'(plo) + {prod[33:0], 32'd0} + 66'd32768;
  assign mv_mag = mv_sum[63:16];

  assign turn_sum = {1'b0, prod[31:0]} + HEAD_ROUND;
  assign step     = turn_sum[31:32-HB];

  always_comb begin
    unique case (cmd.mul_sel)
      ddo_pkg::MUL_TRAVEL: begin
        mul_a = dmag;
        mul_b = dist_per_count;
      end
      ddo_pkg::MUL_MOVE_LO: begin
        mul_a = mean_mag[31:0];
        mul_b = 32'(rom_q);
      end
      ddo_pkg::MUL_MOVE_HI: begin
        mul_a = 32'(mean_mag[47:32]);
        mul_b = 32'(rom_q);
      end
      ddo_pkg::MUL_TURN: begin
        mul_a = diff32;
        mul_b = 32'(inv_wheel_base);
      end
      default: begin
        mul_a = dmag;
        mul_b = dist_per_count;
      end
    endcase
  end

  // sine index: nearest table entry within the quadrant, mirrored on odd quadrants
  assign ang      = cmd.rom_cos ? (head + QUARTER) : head;
  assign quad     = ang[HB-1:HB-2];
  assign frac     = ang[RW-1:0];
  assign idx_wide = ((AMUL_W'(frac) * DEPTH_W) + ROUND_IDX) >> RW;
  assign idx_c    = (idx_wide > DEPTH_W) ? DEPTH_IDX : idx_wide[IDX_W-1:0];
  assign rom_addr = quad[0] ? (DEPTH_IDX - idx_c) : idx_c;

  ddo_sine_rom #(
    .DEPTH (SINE_TABLE_DEPTH)
  ) u_rom (
    .clk  (clk),
    .rd   (cmd.rom_rd),
    .addr (rom_addr),
    .data (rom_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_per_count <= ddo_pkg::DPC_RESET;
      inv_wheel_base <= ddo_pkg::IWB_RESET;
      min_interval   <= ddo_pkg::MINT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ddo_pkg::REG_DIST_PER_COUNT: dist_per_count <= cfg_data;
        ddo_pkg::REG_INV_WHEEL_BASE: inv_wheel_base <= cfg_data[ddo_pkg::IWB_W-1:0];
        ddo_pkg::REG_MIN_INTERVAL:   min_interval   <= cfg_data[ddo_pkg::MINT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_left  <= '0;
      prev_right <= '0;
      last_time  <= '0;
      first_seen <= 1'b0;
      pos_x      <= '0;
      pos_y      <= '0;
      head       <= '0;
    end else begin
      if (cmd.set_first) begin
        first_seen <= 1'b1;
      end
      if (cmd.commit) begin
        prev_left  <= in_l;
        prev_right <= in_r;
        last_time  <= in_t;
      end
      if (cmd.upd_x) begin
        pos_x <= sat_add(pos_x, move);
      end
      if (cmd.upd_y) begin
        pos_y <= sat_add(pos_y, move);
      end
      if (cmd.upd_head) begin
        head <= head + step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_t <= time_stamp;
      in_l <= left_count;
      in_r <= right_count;
    end
    if (cmd.check) begin
      acc_q <= status.acc;
    end
    if (cmd.load_dl || cmd.load_dr) begin
      dmag <= dabs[31:0];
      dneg <= dsel[32];
    end
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.load_tl) begin
      tl <= trav_val;
    end
    if (cmd.load_tr) begin
      tr <= trav_val;
    end
    if (cmd.load_sum) begin
      wsum   <= {tl[48], tl} + {tr[48], tr};
      diff32 <= tr[31:0] - tl[31:0];
    end
    // mean truncates toward zero
    if (cmd.load_mean) begin
      mean_mag <= mabs[48:1];
      mean_neg <= wsum[49];
    end
    if (cmd.rom_rd) begin
      trig_neg <= quad[1];
    end
    if (cmd.save_lo) begin
      plo <= prod[48:0];
    end
    if (cmd.load_move) begin
      move <= (mean_neg ^ trig_neg) ? (49'sd0 - $signed({1'b0, mv_mag}))
                                    : $signed({1'b0, mv_mag});
    end
    if (cmd.load_out) begin
      out_acc  <= acc_q;
      out_x    <= pos_x;
      out_y    <= pos_y;
      out_head <= head16;
    end
  end

  if (HB >= ddo_pkg::HEADOUT_W) begin : g_head_wide
    assign head16 = head[HB-1 -: ddo_pkg::HEADOUT_W];
  end else begin : g_head_narrow
    assign head16 = {head, {(ddo_pkg::HEADOUT_W - HB){1'b0}}};
  end

  assign accepted = out_acc;
  assign x_pos    = out_x;
  assign y_pos    = out_y;
  assign heading  = out_head;

endmodule

[rtl/core/ddo_ctrl.sv]
// ----------------------------------------------------------------------------
// ddo_ctrl
// sequencer for one sample: interval check, travel, move, turn, result beat
// ----------------------------------------------------------------------------
module ddo_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  ddo_pkg::ddo_status_t  status,
  output ddo_pkg::ddo_cmd_t     cmd
);

  typedef enum logic [17:0] {
    IDLE    = 18'h00001,
    CHECK   = 18'h00002,
    DELTA_L = 18'h00004,
    MUL_L   = 18'h00008,
    TRAV_L  = 18'h00010,
    MUL_R   = 18'h00020,
    TRAV_R  = 18'h00040,
    SUM     = 18'h00080,
    MEAN    = 18'h00100,
    X_LO    = 18'h00200,
    X_HI    = 18'h00400,
    X_SUM   = 18'h00800,
    Y_LO    = 18'h01000,
    Y_HI    = 18'h02000,
    Y_SUM   = 18'h04000,
    Y_POS   = 18'h08000,
    HEAD    = 18'h10000,
    DONE    = 18'h20000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == IDLE);

  always_comb begin
    cmd         = '0;
    cmd.mul_sel = ddo_pkg::MUL_TRAVEL;
    state_next  = state;
    unique case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = CHECK;
        end
      end
      CHECK: begin
        cmd.check = 1'b1;
        if (!status.acc) begin
          state_next = DONE;
        end else if (!status.first_seen) begin
          // first sample only records counts and time
          cmd.set_first = 1'b1;
          cmd.commit    = 1'b1;
          state_next    = DONE;
        end else begin
          state_next = DELTA_L;
        end
      end
      DELTA_L: begin
        cmd.load_dl = 1'b1;
        state_next  = MUL_L;
      end
      MUL_L: begin
        cmd.mul_en = 1'b1;
        state_next = TRAV_L;
      end
      TRAV_L: begin
        cmd.load_tl = 1'b1;
        cmd.load_dr = 1'b1;
        state_next  = MUL_R;
      end
      MUL_R: begin
        cmd.mul_en = 1'b1;
        state_next = TRAV_R;
      end
      TRAV_R: begin
        cmd.load_tr = 1'b1;
        state_next  = SUM;
      end
      SUM: begin
        cmd.load_sum = 1'b1;
        state_next   = MEAN;
      end
      MEAN: begin
        cmd.load_mean = 1'b1;
        cmd.rom_rd    = 1'b1;
        cmd.rom_cos   = 1'b1;
        state_next    = X_LO;
      end
      X_LO: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = ddo_pkg::MUL_MOVE_LO;
        state_next  = X_HI;
      end
      X_HI: begin
        cmd.save_lo = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = ddo_pkg::MUL_MOVE_HI;
        state_next  = X_SUM;
      end
      X_SUM: begin
        cmd.load_move = 1'b1;
        cmd.rom_rd    = 1'b1;
        state_next    = Y_LO;
      end
      Y_LO: begin
        cmd.upd_x   = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = ddo_pkg::MUL_MOVE_LO;
        state_next  = Y_HI;
      end
      Y_HI: begin
        cmd.save_lo = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = ddo_pkg::MUL_MOVE_HI;
        state_next  = Y_SUM;
      end
      Y_SUM: begin
        cmd.load_move = 1'b1;
        state_next    = Y_POS;
      end
      Y_POS: begin
        cmd.upd_y   = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = ddo_pkg::MUL_TURN;
        state_next  = HEAD;
      end
      HEAD: begin
        cmd.upd_head = 1'b1;
        cmd.commit   = 1'b1;
        state_next   = DONE;
      end
      DONE: begin
        // hold until the previous beat has left the output register
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/core/differential_drive_odometry_top.sv]
// ----------------------------------------------------------------------------
// differential_drive_odometry_top
// wheel odometry for a two-wheel robot: pose from time-stamped encoder counts
// ----------------------------------------------------------------------------
// sample channel: time stamp plus cumulative left/right counts, one beat each
// pose channel: one beat per sample with accepted flag, x/y (Q32.16) and heading
// cfg channel: register writes (distance per count, inverse base, min interval),
//   always ready, to be used only while no sample is in flight
// a sample that fails the interval check, or the first accepted one, goes
//   from CHECK straight to DONE; a sample that moves the robot runs every step
// the sequencer handles one sample at a time over a single shared 32x32
//   multiplier (two travel products, four move partial products, one turn)
//   and one sine table port, and takes no new sample until the last is done
// the pose sits in an output register: a new sample is taken while the
//   previous beat waits; if the receiver stalls, the finished sample holds in
//   its last step until the register frees up
// reset clears the pose, the stored counts and time, and the first-sample flag,
//   and loads the default register values; the sine table is constant
// ----------------------------------------------------------------------------
`include "differential_drive_odometry_top_macros.svh"

module differential_drive_odometry_top #(
  parameter int HEADING_BITS     = 16,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  ddo_sample_if.sink  sample,
  ddo_pose_if.source  pose,
  ddo_cfg_if.sink     cfg
);

  ddo_pkg::ddo_cmd_t    cmd;
  ddo_pkg::ddo_status_t status;

  assign cfg.ready = 1'b1;

  ddo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (pose.valid),
    .out_ready (pose.ready),
    .status    (status),
    .cmd       (cmd)
  );

  ddo_datapath #(
    .HEADING_BITS     (HEADING_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg.valid && cfg.ready),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .time_stamp  (sample.time_stamp),
    .left_count  (sample.left_count),
    .right_count (sample.right_count),
    .cmd         (cmd),
    .status      (status),
    .accepted    (pose.accepted),
    .x_pos       (pose.x_pos),
    .y_pos       (pose.y_pos),
    .heading     (pose.heading)
  );

  // one sample at a time: busy right after a sample beat
  `DDO_ASSERT_NEXT(a_busy_after_accept, clk, rst, sample.valid && sample.ready, !sample.ready, "sample taken while busy")

  // a result never overwrites a beat that is still waiting
  `DDO_ASSERT_SAME(a_no_overwrite, clk, rst, cmd.load_out, !pose.valid || pose.ready, "pose overwritten")

  // loading the output register raises valid
  `DDO_ASSERT_NEXT(a_load_valid, clk, rst, cmd.load_out, pose.valid, "pose load without valid")

  // the capture strobe only fires on a sample beat
  `DDO_ASSERT_SAME(a_capture_beat, clk, rst, cmd.capture, sample.valid && sample.ready, "capture without beat")

endmodule

[dv/ddo_pose_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_pose_checker
// watches the sample, pose and register write channels of the odometry block,
// keeps its own copy of registers, stored counts and pose, predicts the pose
// beat of every sample taken and compares each pose beat field by field
// ----------------------------------------------------------------------------
module ddo_pose_checker
  import ddo_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  ddo_sample_if    sample,
  ddo_pose_if      pose,
  ddo_cfg_if       cfg,
  output int       mismatches,
  output int       poses_due
);

  localparam int HEAD_W      = 16;
  localparam int TABLE_DEPTH = 256;

  typedef longint unsigned u64_t;

  typedef struct {
    logic                    accepted;
    logic signed [POS_W-1:0] x_pos;
    logic signed [POS_W-1:0] y_pos;
    logic [HEADOUT_W-1:0]    heading;
  } pose_t;

  int sine_q16 [0:TABLE_DEPTH];

  // register copies
  logic [DPC_W-1:0]  dist_per_count;
  logic [IWB_W-1:0]  inv_base;
  logic [MINT_W-1:0] min_gap;

  // odometry state
  logic signed [COUNT_W-1:0] last_left;
  logic signed [COUNT_W-1:0] last_right;
  logic [TIME_W-1:0]         last_stamp;
  logic                      have_origin;
  logic signed [POS_W-1:0]   pos_x;
  logic signed [POS_W-1:0]   pos_y;
  logic [HEAD_W-1:0]         heading_q;

  pose_t poses_expected[$];
  pose_t want;
  int    fails;

  // quarter-wave sine, Q1.16, from an integer Taylor series
  initial begin : sine_table_init
    longint unsigned ang;
    longint unsigned ang2;
    longint unsigned term;
    longint          sum;
    fails = 0;
    for (int k = 0; k <= TABLE_DEPTH; k++) begin
      ang  = (u64_t'(k) * HALF_PI_Q30) / TABLE_DEPTH;
      ang2 = (ang * ang) >> 30;
      term = ang;
      sum  = longint'(ang);
      for (int n = 1; n <= 6; n++) begin
        term = ((term * ang2) >> 30) / u64_t'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) sum -= longint'(term);
        else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      sum = (sum + 8192) / 16384;
      if (sum > 65536) sum = 65536;
      sine_q16[k] = int'(sum);
    end
  end

  function automatic int quarter_sine(logic [HEAD_W-1:0] ang);
    logic [1:0]      quad;
    longint unsigned idx;
    quad = ang[HEAD_W-1 -: 2];
    idx  = (u64_t'(ang[HEAD_W-3:0]) * TABLE_DEPTH + (1 << (HEAD_W - 3)))
           >> (HEAD_W - 2);
    if (idx > TABLE_DEPTH) idx = TABLE_DEPTH;
    if (quad[0]) idx = TABLE_DEPTH - idx;
    return quad[1] ? -sine_q16[idx] : sine_q16[idx];
  endfunction

  // v * f / 2^16, magnitude rounded half up, sign put back
  function automatic longint scale_frac(longint v, longint unsigned f);
    logic            neg;
    longint unsigned mag;
    longint unsigned m;
    neg = v < 0;
    mag = neg ? u64_t'(-v) : u64_t'(v);
    m   = (mag * f + 64'd32768) >> 16;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint project(longint mean, int trig);
    longint d;
    d = scale_frac(mean, u64_t'(trig < 0 ? -trig : trig));
    return trig < 0 ? -d : d;
  endfunction

  function automatic logic signed [POS_W-1:0] clamp_pos(longint v);
    if (v > longint'(POS_MAX)) return POS_MAX;
    if (v < longint'(POS_MIN)) return POS_MIN;
    return v[POS_W-1:0];
  endfunction

  function automatic pose_t advance_odometry(logic [TIME_W-1:0] stamp,
                                             logic signed [COUNT_W-1:0] left,
                                             logic signed [COUNT_W-1:0] right);
    pose_t           p;
    logic [TIME_W-1:0] gap;
    longint          tl;
    longint          tr;
    longint          mean;
    int              sin_v;
    int              cos_v;
    longint unsigned turn;
    longint unsigned step;
    gap = stamp - last_stamp;
    p.accepted = gap > TIME_W'(min_gap);
    if (p.accepted) begin
      if (have_origin) begin
        tl    = scale_frac(longint'(left) - longint'(last_left), dist_per_count);
        tr    = scale_frac(longint'(right) - longint'(last_right), dist_per_count);
        mean  = (tl + tr) / 2;
        // move along the old heading, then turn
        sin_v = quarter_sine(heading_q);
        cos_v = quarter_sine(heading_q + HEAD_W'(1 << (HEAD_W - 2)));
        pos_x = clamp_pos(longint'(pos_x) + project(mean, cos_v));
        pos_y = clamp_pos(longint'(pos_y) + project(mean, sin_v));
        turn  = u64_t'(tr - tl) * u64_t'(inv_base);
        step  = (turn + (64'd1 << (31 - HEAD_W))) >> (32 - HEAD_W);
        heading_q = heading_q + HEAD_W'(step);
      end else begin
        have_origin = 1'b1;
      end
      last_left  = left;
      last_right = right;
      last_stamp = stamp;
    end
    p.x_pos   = pos_x;
    p.y_pos   = pos_y;
    p.heading = heading_q;
    return p;
  endfunction

  task automatic compare_field(string field, logic [POS_W-1:0] exp_v,
                               logic [POS_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: pose %s mismatch, expected %h, actual %h",
               $time, field, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      dist_per_count = DPC_RESET;
      inv_base       = IWB_RESET;
      min_gap        = MINT_RESET;
      last_left      = '0;
      last_right     = '0;
      last_stamp     = '0;
      have_origin    = 1'b0;
      pos_x          = '0;
      pos_y          = '0;
      heading_q      = '0;
      poses_expected.delete();
      poses_due      <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_DIST_PER_COUNT: dist_per_count = cfg.data[DPC_W-1:0];
          REG_INV_WHEEL_BASE: inv_base = cfg.data[IWB_W-1:0];
          REG_MIN_INTERVAL:   min_gap = cfg.data[MINT_W-1:0];
          default: ;
        endcase
      end
      if (pose.valid && pose.ready) begin
        if (poses_expected.size() == 0) begin
          $display("%0t: pose beat with none expected, expected nothing, actual %h %h %h %h",
                   $time, pose.accepted, pose.x_pos, pose.y_pos, pose.heading);
          fails++;
        end else begin
          want = poses_expected.pop_front();
          compare_field("accepted", POS_W'(want.accepted), POS_W'(pose.accepted));
          compare_field("x_pos", want.x_pos, pose.x_pos);
          compare_field("y_pos", want.y_pos, pose.y_pos);
          compare_field("heading", POS_W'(want.heading), POS_W'(pose.heading));
        end
      end
      if (sample.valid && sample.ready)
        poses_expected.push_back(advance_odometry(sample.time_stamp, sample.left_count,
                                                  sample.right_count));
      poses_due <= poses_expected.size();
    end
    mismatches <= fails;
  end

endmodule

[dv/tb_differential_drive_odometry_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_differential_drive_odometry_top
// drives encoder samples and register writes into the odometry block: a
// directed run over interval edges, backward time, count extremes and
// position saturation, then randomized motion under several register
// settings with random stalls on both channels; ddo_pose_checker predicts
// and checks every pose beat
// ----------------------------------------------------------------------------
module tb_differential_drive_odometry_top;
  import ddo_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD   = 300;
  localparam int SETTLE      = 24;
  localparam int PHASE_ITEMS = 128;

  logic clk;
  logic rst;

  ddo_sample_if sample_ch ();
  ddo_pose_if   pose_ch ();
  ddo_cfg_if    cfg_ch ();

  int mismatches;
  int poses_due;

  logic                      quiet = 1'b0;
  logic                      long_hold_req = 1'b0;
  logic [TIME_W-1:0]         t_now = '0;
  logic signed [COUNT_W-1:0] l_now = '0;
  logic signed [COUNT_W-1:0] r_now = '0;
  logic [MINT_W-1:0]         mint_now = MINT_RESET;

  differential_drive_odometry_top dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .pose   (pose_ch),
    .cfg    (cfg_ch)
  );

  ddo_pose_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .sample     (sample_ch),
    .pose       (pose_ch),
    .cfg        (cfg_ch),
    .mismatches (mismatches),
    .poses_due  (poses_due)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // pose receiver: random stall bursts, one long hold on request
  initial begin : pose_ready_gen
    logic hold_done;
    hold_done = 1'b0;
    pose_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (long_hold_req && !hold_done) begin
        hold_done = 1'b1;
        pose_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        pose_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      pose_ch.ready <= 1'b1;
      repeat ($urandom_range(0, 7) == 0 ? $urandom_range(50, 150) : $urandom_range(1, 24))
        @(posedge clk);
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((sample_ch.valid && sample_ch.ready) || (pose_ch.valid && pose_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle = 0;
      else
        idle++;
    end
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_sample(logic [TIME_W-1:0] stamp, logic signed [COUNT_W-1:0] left,
                             logic signed [COUNT_W-1:0] right);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    t_now = stamp;
    l_now = left;
    r_now = right;
    sample_ch.valid       <= 1'b1;
    sample_ch.time_stamp  <= stamp;
    sample_ch.left_count  <= left;
    sample_ch.right_count <= right;
    do @(posedge clk); while (!sample_ch.ready);
  endtask

  // stop offering and wait until every pose beat is back
  task automatic drain();
    sample_ch.valid <= 1'b0;
    do @(posedge clk); while (poses_due != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic program_regs(logic [CFG_DAT_W-1:0] dpc, logic [CFG_DAT_W-1:0] iwb,
                              logic [CFG_DAT_W-1:0] mint, logic poke_unused);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [CFG_DAT_W-1:0] val [4];
    idx = '{REG_DIST_PER_COUNT, REG_INV_WHEEL_BASE, REG_MIN_INTERVAL, REG_UNUSED};
    val = '{dpc, iwb, mint, $urandom()};
    mint_now = mint[MINT_W-1:0];
    for (int i = 0; i < (poke_unused ? 4 : 3); i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[i];
      cfg_ch.data  <= val[i];
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [COUNT_W-1:0] wheel_step();
    int k;
    k = $urandom_range(0, 9);
    if (k < 7) return $urandom_range(0, 4000) - 2000;
    if (k < 9) return $urandom_range(0, 2097152) - 1048576;
    return $urandom();
  endfunction

  task automatic run_phase(logic hold_phase, logic pause_phase);
    int                  kind;
    logic [COUNT_W-1:0]  dl;
    logic [TIME_W-1:0]   ts;
    logic [COUNT_W-1:0]  nl;
    logic [COUNT_W-1:0]  nr;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (hold_phase && i == 8) long_hold_req <= 1'b1;
      if (pause_phase && i == PHASE_ITEMS / 2) begin
        sample_ch.valid <= 1'b0;
        do @(posedge clk); while (poses_due != 0);
      end
      kind = $urandom_range(0, 99);
      ts = t_now;
      nl = l_now;
      nr = r_now;
      if (kind < 7) begin
        // noise: anything at all
        ts = $urandom();
        nl = $urandom();
        nr = $urandom();
      end else if (kind < 20) begin
        // too early after the last sample sent, rejected when that one was accepted
        ts = t_now + $urandom_range(0, mint_now);
      end else begin
        ts = t_now + mint_now + 1 + $urandom_range(0, 20000);
        dl = wheel_step();
        nl = l_now + dl;
        nr = ($urandom_range(0, 3) == 0) ? r_now + dl : r_now + wheel_step();
      end
      send_sample(ts, nl, nr);
    end
  endtask

  initial begin : stimulus
    rst <= 1'b1;
    sample_ch.valid       <= 1'b0;
    sample_ch.time_stamp  <= '0;
    sample_ch.left_count  <= '0;
    sample_ch.right_count <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_DIST_PER_COUNT;
    cfg_ch.data  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // interval edges and turning through the quadrants at reset settings
    send_sample(32'd0, 32'sd0, 32'sd0);
    send_sample(32'd10000, 32'sd0, 32'sd0);
    send_sample(32'd10001, 32'sd100, 32'sd100);
    send_sample(32'd20001, 32'sd500, 32'sd500);
    send_sample(32'd20002, 32'sd1100, 32'sd1100);
    send_sample(32'd35000, 32'sd1100, 32'sd5100);
    send_sample(32'd50000, 32'sd3100, 32'sd7100);
    send_sample(32'd65000, 32'sd3100, 32'sd11100);
    send_sample(32'd80000, 32'sd5100, 32'sd13100);
    send_sample(32'd95000, 32'sd9100, 32'sd13100);
    send_sample(32'd110000, 32'sd8100, 32'sd12100);
    // time going backwards reads as a long gap
    send_sample(32'd5, 32'sd7000, 32'sd14000);
    send_sample(32'hFFFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_sample(32'd0, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_sample(32'd20000, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_sample(32'd40000, 32'shFFFF_FFFF, 32'sh0000_0000);
    drain();

    // largest travel per count, no turning: drives x/y into saturation
    program_regs(32'hFFFF_FFFF, 32'd0, 32'd0, 1'b0);
    send_sample(32'd40000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_sample(32'd40001, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_sample(32'd40002, 32'sh8000_0000, 32'sh8000_0000);
    send_sample(32'd40003, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_sample(32'd40004, 32'sh8000_0000, 32'sh8000_0000);
    send_sample(32'd40005, 32'sh8000_0000, 32'sh8000_0000);
    send_sample(32'd40006, 32'sd0, 32'sd0);
    drain();

    program_regs(DPC_RESET, IWB_RESET, MINT_RESET, 1'b0);
    run_phase(1'b0, 1'b0);
    drain();
    program_regs(32'd0, 32'h00FF_FFFF, 32'd1000000, 1'b0);
    run_phase(1'b0, 1'b0);
    drain();
    program_regs($urandom_range(1, 1 << 24), $urandom_range(0, 24'hFF_FFFF),
                 $urandom_range(0, 50000), 1'b0);
    run_phase(1'b1, 1'b0);
    drain();
    program_regs($urandom(), $urandom_range(0, 24'hFF_FFFF), 32'd0, 1'b1);
    run_phase(1'b0, 1'b1);
    drain();
    // data beyond the register widths, plus a write to an unused index
    program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    run_phase(1'b0, 1'b0);
    drain();
    program_regs($urandom(), $urandom(), $urandom_range(0, 1000000), 1'b0);
    run_phase(1'b0, 1'b0);
    drain();
    program_regs($urandom_range(100000, 2000000), $urandom_range(1000, 100000),
                 $urandom_range(0, 20000), 1'b0);
    run_phase(1'b0, 1'b0);
    drain();
    quiet <= 1'b1;
    program_regs($urandom_range(100000, 2000000), $urandom_range(1000, 100000),
                 $urandom_range(0, 20000), 1'b0);
    run_phase(1'b0, 1'b0);
    drain();

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
